// File: rtl/core/slsd_pkg.sv
package slsd_pkg;

	localparam int LOAD_W  = 20;
	localparam int SOLAR_W = 19;
	localparam int DELTA_W = 20;
	localparam int HOUR_W  = 5;
	localparam int DEV_W   = 8;
	localparam int EST_W   = 7;

	localparam int HISTORY_DEPTH_DEF = 360;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHEAP_START     = 2'd0,
		REG_CHEAP_END       = 2'd1,
		REG_SOLAR_THRESHOLD = 2'd2,
		REG_MAX_DEVICES     = 2'd3
	} cfg_reg_t;

	localparam logic [HOUR_W-1:0]  CHEAP_START_RST = 5'd22;
	localparam logic [HOUR_W-1:0]  CHEAP_END_RST   = 5'd6;
	localparam logic [SOLAR_W-1:0] THRESHOLD_RST   = 19'd8000;
	localparam logic [DEV_W-1:0]   MAX_DEVICES_RST = 8'd10;
	localparam logic [HOUR_W-1:0]  LAST_HOUR       = 5'd23;

	localparam logic [DELTA_W-1:0] DELTA_SAT = 20'd1000000;
	localparam int                 MIN_FILL  = 6;

	localparam logic [EST_W-1:0] EST_BASE_HI   = 7'd55;
	localparam logic [EST_W-1:0] EST_BASE_LO   = 7'd15;
	localparam logic [EST_W-1:0] EST_FEW_ADD   = 7'd25;
	localparam logic [EST_W-1:0] EST_RISE_ADD  = 7'd35;
	localparam logic [EST_W-1:0] EST_STRONG    = 7'd10;
	localparam logic [EST_W-1:0] EST_CAP       = 7'd98;
	localparam logic [EST_W-1:0] EST_SHIFT_MIN = 7'd65;

	// floor(x / 2400) == (x * DEV_RECIP) >> DEV_RECIP_SHIFT for x < 2**19
	localparam int              DEV_RECIP_SHIFT = 32;
	localparam int              DEV_RECIP_W     = 21;
	localparam int              QUOT_PROD_W     = SOLAR_W + DEV_RECIP_W;
	localparam logic [DEV_RECIP_W-1:0] DEV_RECIP =
		DEV_RECIP_W'((64'd1 << DEV_RECIP_SHIFT) / 64'd2400 + 64'd1);

	typedef struct packed {
		logic cheap;
		logic above;
		logic boost;
		logic surplus;
		logic few;
		logic sum_low;
	} slsd_flags_t;

endpackage

// File: rtl/core/slsd_if.sv
interface slsd_in_if;
	logic                         valid;
	logic                         ready;
	logic [slsd_pkg::LOAD_W-1:0]  load_power;
	logic [slsd_pkg::SOLAR_W-1:0] solar_power;
	logic [slsd_pkg::DELTA_W-1:0] solar_energy_delta;
	logic [slsd_pkg::HOUR_W-1:0]  hour;

	modport source (output valid, load_power, solar_power, solar_energy_delta, hour,
		input ready);
	modport sink (input valid, load_power, solar_power, solar_energy_delta, hour,
		output ready);
endinterface

interface slsd_out_if;
	logic                       valid;
	logic                       ready;
	logic                       run_loads;
	logic [slsd_pkg::DEV_W-1:0] plug_count;
	logic [slsd_pkg::EST_W-1:0] solar_estimate;

	modport source (output valid, run_loads, plug_count, solar_estimate, input ready);
	modport sink (input valid, run_loads, plug_count, solar_estimate, output ready);
endinterface

// File: rtl/core/slsd_ring.sv
module slsd_ring #(
	parameter int DEPTH = slsd_pkg::HISTORY_DEPTH_DEF,
	parameter int WIDTH = slsd_pkg::DELTA_W
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	import slsd_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: rdata returns the entry being replaced
	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

// File: rtl/core/slsd_decide.sv
module slsd_decide #(
	parameter int HISTORY_DEPTH = slsd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 v_s1,
	input  slsd_pkg::slsd_flags_t                                flags,
	input  logic [slsd_pkg::DELTA_W+$clog2(HISTORY_DEPTH+1)-1:0] prod,
	input  logic [slsd_pkg::DELTA_W+$clog2(HISTORY_DEPTH+1)-1:0] sum,
	input  logic [slsd_pkg::DEV_W-1:0]                           quot,
	input  logic [slsd_pkg::DEV_W-1:0]                           max_devices,
	output logic                                                 adv,
	slsd_out_if.source                                           result
);
	import slsd_pkg::*;

	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int PROD_W = DELTA_W + FILL_W;
	localparam int CMP_W  = PROD_W + 3;

	logic              v_s2;
	slsd_flags_t       flags_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0] sum_s2;
	logic [DEV_W-1:0]  quot_s2;

	logic              out_valid_q;
	logic              shift_q;
	logic [DEV_W-1:0]  devs_q;
	logic [EST_W-1:0]  est_q;

	logic [CMP_W-1:0]  lhs;
	logic [CMP_W-1:0]  rhs;
	logic              rising;
	logic [EST_W-1:0]  est_sum;
	logic [EST_W-1:0]  est;
	logic              shift;
	logic [DEV_W-1:0]  devs_raw;
	logic [DEV_W-1:0]  devs_min;
	logic [DEV_W-1:0]  devs_cap;

	assign adv = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= flags;
			prod_s2  <= prod;
			sum_s2   <= sum;
			quot_s2  <= quot;
		end
	end

	// 5*delta*fill > 6*sum
	assign lhs    = (CMP_W'(prod_s2) << 2) + CMP_W'(prod_s2);
	assign rhs    = (CMP_W'(sum_s2) << 2) + (CMP_W'(sum_s2) << 1);
	assign rising = flags_s2.few || (lhs > rhs);

	always_comb begin
		est_sum = flags_s2.above ? EST_BASE_HI : EST_BASE_LO;
		priority if (flags_s2.few) begin
			if (flags_s2.above) est_sum = est_sum + EST_FEW_ADD;
		end else if (flags_s2.sum_low) begin
			if (flags_s2.above) est_sum = est_sum + EST_RISE_ADD;
		end else if (rising) begin
			est_sum = est_sum + EST_RISE_ADD;
		end
		if (flags_s2.boost) est_sum = est_sum + EST_STRONG;
		est = (est_sum > EST_CAP) ? EST_CAP : est_sum;
	end

	assign shift = flags_s2.cheap && flags_s2.surplus && flags_s2.above && rising &&
		(est >= EST_SHIFT_MIN);

	assign devs_raw = flags_s2.surplus ? quot_s2 : '0;
	assign devs_min = (devs_raw == '0) ? DEV_W'(1) : devs_raw;
	assign devs_cap = (devs_min > max_devices) ? max_devices : devs_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shift_q <= shift;
			devs_q  <= shift ? devs_cap : '0;
			est_q   <= est;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.run_loads      = shift_q;
	assign result.plug_count     = devs_q;
	assign result.solar_estimate = est_q;

	as_idle_no_devices: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !shift_q |-> devs_q == '0)
		else $error("devices on while idle");
	as_est_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> est_q <= EST_CAP)
		else $error("estimate above cap");
	as_shift_est: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && shift_q |-> est_q >= EST_SHIFT_MIN)
		else $error("shift with low estimate");

endmodule

// File: rtl/core/solar_load_shift_decision.sv
// Each transaction passes the s1, s2 and output registers in turn. Throughput: one
// transaction per cycle unless the output stalls; the ring memory is read and written
// once per transaction on a single read-first port, and the running sum updates once
// per transaction. Output stalls hold the whole pipeline. Reset clears pointer, fill
// count, sum, pipeline valids and configuration; ring contents are not cleared.
module solar_load_shift_decision #(
	parameter int HISTORY_DEPTH = slsd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [slsd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [slsd_pkg::CFG_DATA_W-1:0] wr_data,
	slsd_in_if.sink                         sample,
	slsd_out_if.source                      result
);
	import slsd_pkg::*;

	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = DELTA_W + FILL_W;

	logic [HOUR_W-1:0]  cheap_start_q;
	logic [HOUR_W-1:0]  cheap_end_q;
	logic [SOLAR_W-1:0] threshold_q;
	logic [DEV_W-1:0]   max_devices_q;

	logic               adv;
	logic               accept;
	logic [DELTA_W-1:0] delta_sat;

	logic               v_s1;
	logic [SOLAR_W-1:0] solar_s1;
	logic [DELTA_W-1:0] delta_s1;
	logic [HOUR_W-1:0]  hour_s1;
	logic               surplus_s1;
	logic [SOLAR_W-1:0] diff_s1;
	logic [DELTA_W-1:0] old_delta;

	logic [PTR_W-1:0]   wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic               full;

	logic               cheap;
	slsd_flags_t        flags;
	logic [SUM_W-1:0]   prod;
	logic [QUOT_PROD_W-1:0] quot_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cheap_start_q <= CHEAP_START_RST;
			cheap_end_q   <= CHEAP_END_RST;
			threshold_q   <= THRESHOLD_RST;
			max_devices_q <= MAX_DEVICES_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_CHEAP_START:     cheap_start_q <= wr_data[HOUR_W-1:0];
				REG_CHEAP_END:       cheap_end_q   <= wr_data[HOUR_W-1:0];
				REG_SOLAR_THRESHOLD: threshold_q   <= wr_data[SOLAR_W-1:0];
				REG_MAX_DEVICES:     max_devices_q <= wr_data[DEV_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample.ready = adv;
	assign accept       = sample.valid && adv;
	assign delta_sat    = (sample.solar_energy_delta > DELTA_SAT) ? DELTA_SAT :
		sample.solar_energy_delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wp_q <= '0;
		end else if (adv) begin
			v_s1 <= sample.valid;
			if (sample.valid) begin
				wp_q <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			solar_s1   <= sample.solar_power;
			delta_s1   <= delta_sat;
			hour_s1    <= sample.hour;
			surplus_s1 <= LOAD_W'(sample.solar_power) > sample.load_power;
			diff_s1    <= SOLAR_W'(LOAD_W'(sample.solar_power) - sample.load_power);
		end
	end

	slsd_ring #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (DELTA_W)
	) u_ring (
		.clk   (clk),
		.en    (accept),
		.addr  (wp_q),
		.wdata (delta_sat),
		.rdata (old_delta)
	);

	assign full = (fill_q == FILL_W'(HISTORY_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (adv && v_s1) begin
			if (!full) fill_q <= fill_q + 1'b1;
			sum_q <= sum_q - (full ? SUM_W'(old_delta) : '0) + SUM_W'(delta_s1);
		end
	end

	always_comb begin
		priority if (hour_s1 > LAST_HOUR || cheap_start_q > LAST_HOUR ||
			cheap_end_q > LAST_HOUR) begin
			cheap = 1'b0;
		end else if (cheap_start_q == cheap_end_q) begin
			cheap = 1'b1;
		end else if (cheap_start_q < cheap_end_q) begin
			cheap = (hour_s1 >= cheap_start_q) && (hour_s1 < cheap_end_q);
		end else begin
			cheap = (hour_s1 >= cheap_start_q) || (hour_s1 < cheap_end_q);
		end
	end

	assign flags.cheap   = cheap;
	assign flags.above   = solar_s1 >= threshold_q;
	assign flags.boost   = ({solar_s1, 1'b0} + (SOLAR_W + 2)'(0)) >
		((SOLAR_W + 2)'(threshold_q) << 1) + (SOLAR_W + 2)'(threshold_q);
	assign flags.surplus = surplus_s1;
	assign flags.few     = fill_q < FILL_W'(MIN_FILL);
	assign flags.sum_low = sum_q <= SUM_W'(fill_q);

	assign prod      = SUM_W'(delta_s1) * SUM_W'(fill_q);
	assign quot_prod = QUOT_PROD_W'(diff_s1) * QUOT_PROD_W'(DEV_RECIP);

	slsd_decide #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.flags       (flags),
		.prod        (prod),
		.sum         (sum_q),
		.quot        (quot_prod[DEV_RECIP_SHIFT +: DEV_W]),
		.max_devices (max_devices_q),
		.adv         (adv),
		.result      (result)
	);

	as_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HISTORY_DEPTH))
		else $error("fill count beyond depth");
	as_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> sum_q == '0)
		else $error("nonzero sum with empty ring");
	as_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 && !full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count did not advance");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import slsd_pkg::*;

	localparam int          HIST_DEPTH  = HISTORY_DEPTH_DEF;
	localparam int unsigned SOLAR_TOP   = 320000;
	localparam int unsigned DEVICE_STEP = 2400;
	localparam int          IDLE_LIMIT  = 2000;
	localparam int          TAIL_CYCLES = 8;

	typedef struct packed {
		logic [LOAD_W-1:0]  load_power;
		logic [SOLAR_W-1:0] solar_power;
		logic [DELTA_W-1:0] solar_energy_delta;
		logic [HOUR_W-1:0]  hour;
	} sample_t;

	typedef struct packed {
		logic             run_loads;
		logic [DEV_W-1:0] plug_count;
		logic [EST_W-1:0] solar_estimate;
	} decision_t;

	class shift_scoreboard;
		logic [HOUR_W-1:0]  cheap_start = CHEAP_START_RST;
		logic [HOUR_W-1:0]  cheap_end   = CHEAP_END_RST;
		logic [SOLAR_W-1:0] threshold   = THRESHOLD_RST;
		logic [DEV_W-1:0]   max_devices = MAX_DEVICES_RST;
		logic [DELTA_W-1:0] delta_ring [HIST_DEPTH];
		int unsigned        ring_ptr    = 0;
		int unsigned        ring_fill   = 0;
		longint unsigned    delta_sum   = 0;
		decision_t          expected_q [$];
		int                 errors      = 0;

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_CHEAP_START:     cheap_start = value[HOUR_W-1:0];
				REG_CHEAP_END:       cheap_end   = value[HOUR_W-1:0];
				REG_SOLAR_THRESHOLD: threshold   = value[SOLAR_W-1:0];
				REG_MAX_DEVICES:     max_devices = value[DEV_W-1:0];
				default: ;
			endcase
		endfunction

		function bit hour_cheap(logic [HOUR_W-1:0] h);
			if (h > LAST_HOUR || cheap_start > LAST_HOUR || cheap_end > LAST_HOUR)
				return 0;
			if (cheap_start == cheap_end)
				return 1;
			if (cheap_start < cheap_end)
				return h >= cheap_start && h < cheap_end;
			return h >= cheap_start || h < cheap_end;
		endfunction

		function void note_sample(sample_t s);
			longint unsigned delta, fill, solar, load, thr, devs;
			bit              above, few, rising, shift;
			int unsigned     est;
			decision_t       d;
			delta = (s.solar_energy_delta > DELTA_SAT) ? DELTA_SAT : s.solar_energy_delta;
			fill  = ring_fill;
			solar = s.solar_power;
			load  = s.load_power;
			thr   = threshold;
			above  = solar >= thr;
			few    = fill < MIN_FILL;
			rising = few || (5 * delta * fill > 6 * delta_sum);
			est = above ? EST_BASE_HI : EST_BASE_LO;
			if (few) begin
				if (above)
					est += EST_FEW_ADD;
			end else if (delta_sum <= fill) begin
				if (above)
					est += EST_RISE_ADD;
			end else if (rising) begin
				est += EST_RISE_ADD;
			end
			if (2 * solar > 3 * thr)
				est += EST_STRONG;
			if (est > EST_CAP)
				est = EST_CAP;
			shift = hour_cheap(s.hour) && solar > load && above && rising && est >= EST_SHIFT_MIN;
			devs = (solar > load) ? (solar - load) / DEVICE_STEP : 0;
			if (devs > 255)
				devs = 255;
			if (devs == 0 && shift)
				devs = 1;
			if (devs > max_devices)
				devs = max_devices;
			if (!shift)
				devs = 0;
			d.run_loads      = shift;
			d.plug_count     = DEV_W'(devs);
			d.solar_estimate = EST_W'(est);
			expected_q.push_back(d);
			// ring update happens after the decision
			if (ring_fill >= HIST_DEPTH)
				delta_sum -= delta_ring[ring_ptr];
			else
				ring_fill++;
			delta_ring[ring_ptr] = DELTA_W'(delta);
			delta_sum += delta;
			ring_ptr = (ring_ptr + 1) % HIST_DEPTH;
		endfunction

		function void check_result(decision_t got);
			decision_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: shift %0b devices %0d estimate %0d",
					$time, got.run_loads, got.plug_count, got.solar_estimate);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.run_loads !== e.run_loads) begin
				$display("%0t: run_loads expected %0b actual %0b",
					$time, e.run_loads, got.run_loads);
				errors++;
			end
			if (got.plug_count !== e.plug_count) begin
				$display("%0t: plug_count expected %0d actual %0d",
					$time, e.plug_count, got.plug_count);
				errors++;
			end
			if (got.solar_estimate !== e.solar_estimate) begin
				$display("%0t: solar_estimate expected %0d actual %0d",
					$time, e.solar_estimate, got.solar_estimate);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	bit                    calm = 0;
	int unsigned           level = 100000;
	int                    idle_cycles = 0;
	shift_scoreboard       sb = new();

	slsd_in_if  sample ();
	slsd_out_if result ();

	solar_load_shift_decision #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.sample  (sample.sink),
		.result  (result.source)
	);

	always #5 clk = ~clk;

	always @(negedge clk)
		result.ready <= calm || ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready)
			sb.check_result('{result.run_loads, result.plug_count, result.solar_estimate});
		if ((sample.valid && sample.ready === 1'b1) || (result.valid === 1'b1 && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic sample_t to_sample(int unsigned l, int unsigned s, int unsigned d,
		int unsigned h);
		sample_t t;
		t.load_power         = LOAD_W'(l);
		t.solar_power        = SOLAR_W'(s);
		t.solar_energy_delta = DELTA_W'(d);
		t.hour               = HOUR_W'(h);
		return t;
	endfunction

	function automatic sample_t make_sample(bit low_delta);
		int unsigned s, l, d, h;
		if ($urandom_range(99) < 75) begin
			s = $urandom_range(SOLAR_TOP, int'(sb.threshold));
			l = $urandom_range(s);
			h = ($urandom_range(9) == 0) ? $urandom_range(31, 24) : $urandom_range(23);
			d = low_delta ? $urandom_range(2) : $urandom_range(2 * level, level / 2);
		end else begin
			s = $urandom;
			l = $urandom;
			h = $urandom;
			if (low_delta)
				d = $urandom_range(3);
			else if ($urandom_range(4) == 0)
				d = $urandom;
			else
				d = $urandom_range(2 * level, level / 2);
		end
		return to_sample(l, s, d, h);
	endfunction

	task automatic send_sample(input sample_t s);
		while (!calm && $urandom_range(99) < 24) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid              <= 1'b1;
		sample.load_power         <= s.load_power;
		sample.solar_power        <= s.solar_power;
		sample.solar_energy_delta <= s.solar_energy_delta;
		sample.hour               <= s.hour;
		do @(posedge clk); while (sample.ready !== 1'b1);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_DATA_W'(value);
		sb.set_reg(idx, CFG_DATA_W'(value));
		@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned cs, input int unsigned ce,
		input int unsigned thr, input int unsigned maxd, input bit quiet,
		input bit low_delta, input int count);
		drain();
		write_reg(REG_CHEAP_START, cs);
		write_reg(REG_CHEAP_END, ce);
		write_reg(REG_SOLAR_THRESHOLD, thr);
		write_reg(REG_MAX_DEVICES, maxd);
		wr_en <= 1'b0;
		calm  = quiet;
		level = $urandom_range(400000, 50000);
		repeat (count)
			send_sample(make_sample(low_delta));
		calm = 0;
	endtask

	initial begin
		arst_n                    = 1'b0;
		wr_en                     = 1'b0;
		wr_index                  = '0;
		wr_data                   = '0;
		sample.valid              = 1'b0;
		sample.load_power         = '0;
		sample.solar_power        = '0;
		sample.solar_energy_delta = '0;
		sample.hour               = '0;
		result.ready              = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// near-zero history first, so the low-mean branch is reachable
		send_sample(to_sample(0, 0, 0, 0));
		send_sample(to_sample(100, 8000, 1, 22));
		send_sample(to_sample(0, 12001, 0, 23));
		send_sample(to_sample(5000, 9000, 1, 3));
		send_sample(to_sample(0, 7999, 0, 2));
		send_sample(to_sample(2399, 4800, 1, 5));
		send_sample(to_sample(0, 8000, 0, 0));
		send_sample(to_sample(1, 320000, 1, 1));
		send_sample(to_sample(0, 7999, 1, 4));
		send_sample(to_sample(20'hFFFFF, 19'h7FFFF, 20'hFFFFF, 31));
		send_sample(to_sample(0, 320000, 1000000, 22));
		send_sample(to_sample(0, 320000, 1000001, 5));
		send_sample(to_sample(0, 0, 0, 6));
		send_sample(to_sample(1000, 12001, 999999, 23));
		send_sample(to_sample(12000, 12001, 1000000, 21));
		send_sample(to_sample(0, 320000, 0, 24));
		send_sample(to_sample(0, 9600, 1000000, 0));
		send_sample(to_sample(320000, 320000, 500000, 1));
		send_sample(to_sample(0, 19'h7FFFF, 20'hFFFFF, 5));
		send_sample(to_sample(0, 2400, 3, 2));
		send_sample(to_sample(2400, 4800, 1000000, 3));

		run_phase(8, 17, 4000, 255, 0, 0, 150);
		run_phase(0, 0, 0, 0, 1, 0, 150);
		run_phase(20, 4, 320000, 255, 0, 0, 150);
		run_phase(24, 6, 8000, 3, 0, 0, 150);
		// long enough to flush the ring with tiny deltas
		run_phase(5, 31, 1600, 1, 0, 1, 420);
		run_phase(23, 23, 2400, 255, 0, 0, 200);
		run_phase(0, 23, 100, 10, 0, 0, 160);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
